// ===== src/tcw_pkg.sv =====
`default_nettype none
package tcw_pkg;

   // screen geometry defaults
   localparam int unsigned COLUMNS_DEF  = 80;
   localparam int unsigned ROWS_DEF     = 25;
   localparam int unsigned TAB_STOP_DEF = 8;

   // attribute register value after reset
   localparam logic [7:0] ATTR_RESET = 8'h0f;

   // control characters
   localparam logic [7:0] CH_NEWLINE = 8'd10;
   localparam logic [7:0] CH_RETURN  = 8'd13;
   localparam logic [7:0] CH_TAB     = 8'd9;

   // request operations
   localparam logic OP_PUT  = 1'b0;
   localparam logic OP_READ = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_NEWLINE,
      ST_APPLY,
      ST_WRITE,
      ST_RD_PHYS,
      ST_RD_ADDR,
      ST_RD_ISSUE,
      ST_RD_DATA,
      ST_FINISH
   } state_type;

   // one screen cell as stored in memory
   typedef struct packed {
      logic [7:0] attr;
      logic [7:0] ch;
   } cell_type;

endpackage
`default_nettype wire

// ===== src/tcw_if.sv =====
`default_nettype none
// request channel
interface tcw_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] char_code;
   logic [4:0] read_row;
   logic [6:0] read_col;
   modport source (output valid, op, char_code, read_row, read_col, input ready);
   modport sink   (input valid, op, char_code, read_row, read_col, output ready);
endinterface

// response channel
interface tcw_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] cell_char;
   logic [7:0] cell_attr;
   logic [6:0] cursor_col;
   modport source (output valid, cell_char, cell_attr, cursor_col, input ready);
   modport sink   (input valid, cell_char, cell_attr, cursor_col, output ready);
endinterface

// attribute register write channel
interface tcw_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_attribute;
   modport source (output valid, text_attribute, input ready);
   modport sink   (input valid, text_attribute, output ready);
endinterface
`default_nettype wire

// ===== src/text_console_writer.sv =====
// in-range read: RD_PHYS, RD_ADDR, RD_ISSUE, RD_DATA, FINISH; out-of-range read: FINISH only
// put without scroll: APPLY, then WRITE for a printable byte, then FINISH; each newline,
// including a wrap and the first put after reset, adds a bottom-row clear that walks the memory port
// one request at a time: req_ch.ready is high only while idle
// reset clears all ROWS * COLUMNS cells, one per cycle, before the first request
// the attribute register resets to 0x0f and takes writes at any time
`default_nettype none
module text_console_writer #(
   parameter int unsigned COLUMNS  = tcw_pkg::COLUMNS_DEF,
   parameter int unsigned ROWS     = tcw_pkg::ROWS_DEF,
   parameter int unsigned TAB_STOP = tcw_pkg::TAB_STOP_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   tcw_req_if.sink   req_ch,
   tcw_rsp_if.source rsp_ch,
   tcw_csr_if.sink   csr_ch
);
   import tcw_pkg::*;

   localparam int unsigned DEPTH  = ROWS * COLUMNS;
   localparam int unsigned ADDR_W = $clog2(DEPTH);

   logic [7:0]        attr_ff, attr_in;
   logic              ram_wr_en;
   logic              ram_rd_en;
   logic [ADDR_W-1:0] ram_addr;
   cell_type          ram_wr_data;
   cell_type          ram_rd_data;

   // attribute register
   assign csr_ch.ready = 1'b1;
   assign attr_in = (csr_ch.valid && csr_ch.ready) ? csr_ch.text_attribute : attr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff <= ATTR_RESET;
      end else begin
         attr_ff <= attr_in;
      end
   end

   // sequencer
   tcw_ctrl #(
      .COLUMNS  (COLUMNS),
      .ROWS     (ROWS),
      .TAB_STOP (TAB_STOP)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .attr        (attr_ff),
      .ram_wr_en   (ram_wr_en),
      .ram_rd_en   (ram_rd_en),
      .ram_addr    (ram_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_data (ram_rd_data)
   );

   // screen memory
   tcw_ram #(
      .WIDTH ($bits(cell_type)),
      .DEPTH (DEPTH)
   ) u_screen (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .rd_en   (ram_rd_en),
      .addr    (ram_addr),
      .wr_data (ram_wr_data),
      .rd_data (ram_rd_data)
   );

endmodule
`default_nettype wire

// ===== src/tcw_ram.sv =====
`default_nettype none
module tcw_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 2000
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // single port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== src/tcw_ctrl.sv =====
`default_nettype none
module tcw_ctrl #(
   parameter int unsigned COLUMNS  = tcw_pkg::COLUMNS_DEF,
   parameter int unsigned ROWS     = tcw_pkg::ROWS_DEF,
   parameter int unsigned TAB_STOP = tcw_pkg::TAB_STOP_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   tcw_req_if.sink                                 req_ch,
   tcw_rsp_if.source                               rsp_ch,
   input  wire logic [7:0]                         attr,
   output logic                                    ram_wr_en,
   output logic                                    ram_rd_en,
   output logic [$clog2(ROWS*COLUMNS)-1:0]         ram_addr,
   output tcw_pkg::cell_type                       ram_wr_data,
   input  wire tcw_pkg::cell_type                  ram_rd_data
);
   import tcw_pkg::*;

   localparam int unsigned TOTAL     = ROWS * COLUMNS;
   localparam int unsigned ADDR_W    = $clog2(TOTAL);
   localparam int unsigned ROW_W     = $clog2(ROWS);
   localparam int unsigned CUR_W     = $clog2(COLUMNS + 1);
   localparam int unsigned PH_W      = $clog2(TAB_STOP);
   localparam int unsigned END_PHASE = COLUMNS % TAB_STOP;

   state_type        state_ff, state_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [ADDR_W-1:0] end_ff, end_in;
   logic [ROW_W-1:0]  base_ff, base_in;
   logic [CUR_W-1:0]  cursor_ff, cursor_in;
   logic [PH_W-1:0]   phase_ff, phase_in;
   logic              started_ff, started_in;
   logic [1:0]        nl_left_ff, nl_left_in;
   logic              init_ff, init_in;
   logic [7:0]        char_ff, char_in;
   logic [4:0]        row_ff, row_in;
   logic [6:0]        col_ff, col_in;
   logic [ROW_W-1:0]  phys_ff, phys_in;
   logic [7:0]        res_char_ff, res_char_in;
   logic [7:0]        res_attr_ff, res_attr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_char_ff, rsp_char_in;
   logic [7:0]        rsp_attr_ff, rsp_attr_in;
   logic [6:0]        rsp_cur_ff, rsp_cur_in;

   logic              accept;
   logic              is_nl, is_cr, is_tab, printable, wrap;
   logic              read_in_range;
   logic [1:0]        nl_count;
   logic              slot_free;
   logic              clear_done;
   logic [ROW_W:0]    phys_sum;
   logic [ROW_W-1:0]  bottom_row;
   logic [ADDR_W-1:0] row_start;
   logic [CUR_W:0]    tab_next;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;

   // classify the incoming byte
   assign is_nl     = (req_ch.char_code == CH_NEWLINE);
   assign is_cr     = (req_ch.char_code == CH_RETURN);
   assign is_tab    = (req_ch.char_code == CH_TAB);
   assign printable = !is_nl && !is_cr && !is_tab;
   assign wrap      = started_ff && printable && (cursor_ff >= CUR_W'(COLUMNS));
   assign nl_count  = 2'({1'b0, !started_ff}) + 2'({1'b0, is_nl}) + 2'({1'b0, wrap});

   assign read_in_range = (32'(req_ch.read_row) < ROWS) && (32'(req_ch.read_col) < COLUMNS);

   assign slot_free  = !rsp_valid_ff || rsp_ch.ready;
   assign clear_done = (addr_ff == end_ff);

   // rotating row base: logical row r lives at physical row (base + r) mod ROWS
   assign phys_sum   = (ROW_W+1)'(row_ff) + (ROW_W+1)'(base_ff);
   assign bottom_row = (base_ff == '0) ? ROW_W'(ROWS - 1) : base_ff - ROW_W'(1);
   assign row_start  = ADDR_W'(32'(base_ff) * COLUMNS);
   assign tab_next   = (CUR_W+1)'(cursor_ff) - (CUR_W+1)'(phase_ff) + (CUR_W+1)'(TAB_STOP);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_ch.op == OP_READ) begin
                  state_in = read_in_range ? ST_RD_PHYS : ST_FINISH;
               end else begin
                  state_in = (nl_count != 2'd0) ? ST_NEWLINE : ST_APPLY;
               end
            end
         end
         ST_NEWLINE: state_in = ST_CLEAR;
         ST_CLEAR: begin
            if (clear_done) begin
               priority if (init_ff) begin
                  state_in = ST_IDLE;
               end else if (nl_left_ff != 2'd0) begin
                  state_in = ST_NEWLINE;
               end else begin
                  state_in = ST_APPLY;
               end
            end
         end
         ST_APPLY: begin
            state_in = (char_ff == CH_NEWLINE || char_ff == CH_RETURN || char_ff == CH_TAB)
                       ? ST_FINISH : ST_WRITE;
         end
         ST_WRITE:    state_in = ST_FINISH;
         ST_RD_PHYS:  state_in = ST_RD_ADDR;
         ST_RD_ADDR:  state_in = ST_RD_ISSUE;
         ST_RD_ISSUE: state_in = ST_RD_DATA;
         ST_RD_DATA:  state_in = ST_FINISH;
         ST_FINISH: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      addr_in     = addr_ff;
      end_in      = end_ff;
      base_in     = base_ff;
      cursor_in   = cursor_ff;
      phase_in    = phase_ff;
      started_in  = started_ff;
      nl_left_in  = nl_left_ff;
      init_in     = init_ff;
      char_in     = char_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      phys_in     = phys_ff;
      res_char_in = res_char_ff;
      res_attr_in = res_attr_ff;
      rsp_char_in = rsp_char_ff;
      rsp_attr_in = rsp_attr_ff;
      rsp_cur_in  = rsp_cur_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      ram_wr_en   = 1'b0;
      ram_rd_en   = 1'b0;
      ram_wr_data = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               res_char_in = '0;
               res_attr_in = '0;
               row_in      = req_ch.read_row;
               col_in      = req_ch.read_col;
               char_in     = req_ch.char_code;
               if (req_ch.op == OP_PUT) begin
                  started_in = 1'b1;
                  nl_left_in = nl_count;
               end
            end
         end
         // scroll: the old top row becomes the new bottom row
         ST_NEWLINE: begin
            addr_in    = row_start;
            end_in     = row_start + ADDR_W'(COLUMNS - 1);
            base_in    = (base_ff == ROW_W'(ROWS - 1)) ? '0 : base_ff + ROW_W'(1);
            cursor_in  = '0;
            phase_in   = '0;
            nl_left_in = nl_left_ff - 2'd1;
         end
         // zero fill, one cell per cycle
         ST_CLEAR: begin
            ram_wr_en = 1'b1;
            addr_in   = addr_ff + ADDR_W'(1);
            if (clear_done) begin
               init_in = 1'b0;
            end
         end
         ST_APPLY: begin
            addr_in = ADDR_W'(32'(bottom_row) * COLUMNS + 32'(cursor_ff));
            if (char_ff == CH_RETURN) begin
               cursor_in = '0;
               phase_in  = '0;
            end else if (char_ff == CH_TAB) begin
               if (tab_next > (CUR_W+1)'(COLUMNS)) begin
                  cursor_in = CUR_W'(COLUMNS);
                  phase_in  = PH_W'(END_PHASE);
               end else begin
                  cursor_in = CUR_W'(tab_next);
                  phase_in  = '0;
               end
            end
         end
         ST_WRITE: begin
            ram_wr_en        = 1'b1;
            ram_wr_data.ch   = char_ff;
            ram_wr_data.attr = attr;
            cursor_in        = cursor_ff + CUR_W'(1);
            phase_in         = (phase_ff == PH_W'(TAB_STOP - 1)) ? '0 : phase_ff + PH_W'(1);
         end
         ST_RD_PHYS: begin
            phys_in = (phys_sum >= (ROW_W+1)'(ROWS)) ? ROW_W'(phys_sum - (ROW_W+1)'(ROWS))
                                                     : ROW_W'(phys_sum);
         end
         ST_RD_ADDR: begin
            addr_in = ADDR_W'(32'(phys_ff) * COLUMNS + 32'(col_ff));
         end
         ST_RD_ISSUE: begin
            ram_rd_en = 1'b1;
         end
         ST_RD_DATA: begin
            res_char_in = ram_rd_data.ch;
            res_attr_in = ram_rd_data.attr;
         end
         ST_FINISH: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = res_char_ff;
               rsp_attr_in  = res_attr_ff;
               rsp_cur_in   = 7'(cursor_ff);
            end
         end
         default: begin
         end
      endcase
   end

   assign ram_addr = addr_ff;

   // control registers; reset starts the full screen clear
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         addr_ff      <= '0;
         end_ff       <= ADDR_W'(TOTAL - 1);
         base_ff      <= '0;
         cursor_ff    <= '0;
         phase_ff     <= '0;
         started_ff   <= 1'b0;
         nl_left_ff   <= '0;
         init_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         end_ff       <= end_in;
         base_ff      <= base_in;
         cursor_ff    <= cursor_in;
         phase_ff     <= phase_in;
         started_ff   <= started_in;
         nl_left_ff   <= nl_left_in;
         init_ff      <= init_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      char_ff     <= char_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      phys_ff     <= phys_in;
      res_char_ff <= res_char_in;
      res_attr_ff <= res_attr_in;
      rsp_char_ff <= rsp_char_in;
      rsp_attr_ff <= rsp_attr_in;
      rsp_cur_ff  <= rsp_cur_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.cell_char  = rsp_char_ff;
   assign rsp_ch.cell_attr  = rsp_attr_ff;
   assign rsp_ch.cursor_col = rsp_cur_ff;

   // cursor stays within the row
   a_cursor_bound: assert property (@(posedge clock) disable iff (reset)
      32'(cursor_ff) <= COLUMNS)
      else $error("cursor beyond last column");

   // row base stays a valid row
   a_base_bound: assert property (@(posedge clock) disable iff (reset)
      32'(base_ff) < ROWS)
      else $error("row base out of range");

   // clear sweep never runs past its end
   a_clear_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> addr_ff <= end_ff)
      else $error("clear sweep overran");

   // one request at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != ST_IDLE)
      else $error("request accepted while busy");

endmodule
`default_nettype wire
